>>> src/bswr_pkg.sv
// Package with the shared widths, command and status types and the character translation.
`timescale 1ns / 1ps
`default_nettype none
package bswr_pkg;

  localparam int CUR_W   = 12;
  localparam int CELLS_W = 13;
  localparam int DIV_W   = 16;
  localparam int N_W     = 20;
  localparam int CNT_W   = 4;

  localparam logic [6:0] SPACE_CODE = 7'h20;

  typedef struct packed {
    logic clr_wr;
    logic latch_in;
    logic ld_row;
    logic ld_col;
    logic ld_n;
    logic clamp;
    logic ld_fill;
    logic ld_skip;
    logic dec_skip;
    logic clr_ops;
    logic wr_cell;
    logic wr_fill;
    logic mod_start;
    logic mod_src_cur;
    logic cur_from_rem;
    logic tgt_from_rem;
    logic rd_mem;
    logic out_load;
  } bswr_cmd_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic       action;
    logic       skip_gt1;
    logic       adv_slow;
    logic       mod_busy;
    logic       fill_go;
    logic       clr_last;
    logic       out_free;
  } bswr_sts_t;

  function automatic logic [6:0] ebc_to_ascii(input logic [7:0] c);
    logic [6:0] a;
    a = SPACE_CODE;
    if (c >= 8'hF0 && c <= 8'hF9) a = 7'h30 + 7'(c - 8'hF0);
    else if (c >= 8'hC1 && c <= 8'hC9) a = 7'h41 + 7'(c - 8'hC1);
    else if (c >= 8'hD1 && c <= 8'hD9) a = 7'h4A + 7'(c - 8'hD1);
    else if (c >= 8'hE2 && c <= 8'hE9) a = 7'h53 + 7'(c - 8'hE2);
    else if (c >= 8'h81 && c <= 8'h89) a = 7'h61 + 7'(c - 8'h81);
    else if (c >= 8'h91 && c <= 8'h99) a = 7'h6A + 7'(c - 8'h91);
    else if (c >= 8'hA2 && c <= 8'hA9) a = 7'h73 + 7'(c - 8'hA2);
    else begin
      case (c)
        8'h4B: a = 7'h2E;
        8'h6B: a = 7'h2C;
        8'h60: a = 7'h2D;
        8'h61: a = 7'h2F;
        8'h7A: a = 7'h3A;
        8'h5C: a = 7'h2A;
        8'h4D: a = 7'h28;
        8'h5D: a = 7'h29;
        8'h50: a = 7'h26;
        8'h7C: a = 7'h40;
        8'h5B: a = 7'h24;
        8'h6C: a = 7'h25;
        default: a = SPACE_CODE;
      endcase
    end
    return a;
  endfunction

endpackage
`default_nettype wire

>>> src/block_terminal_stream_screen_writer.sv
// Top level: configuration registers, screen geometry and the controller and datapath.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_tvalid/in_tready | tdata, tlast, tuser
//  out_    | output    | out_tvalid/tready   | tdata
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// After reset the screen memory is swept to spaces, one cell a cycle, all MAX_CELLS cells,
// while no input beat is taken; configuration writes are taken at any time.
// A display byte passes IDLE and EXEC; a read passes IDLE, EXEC, RD and OUT, holding in
// OUT through any output stall. Set-address and repeat-to-address run a 16-step
// remainder unit, and a repeat then writes one cell per cycle through the single memory
// write port while no cursor wrap calls the remainder unit, then returns to IDLE.
`timescale 1ns / 1ps
`default_nettype none
module block_terminal_stream_screen_writer
  import bswr_pkg::*;
#(
  parameter int MAX_CELLS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // data_byte [7:0], read_address [19:8]
  input  wire logic        in_tlast,
  input  wire logic        in_tuser,   // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // cell_code [6:0], cursor_position [18:7]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int CELL_CAP = (MAX_CELLS > 4096) ? 4096 : MAX_CELLS;
  localparam logic [0:0] REG_ROWS = 1'b0;
  localparam logic [0:0] REG_COLS = 1'b1;

  logic [5:0]         row_count_r;
  logic [7:0]         column_count_r;
  logic [5:0]         rows_eff;
  logic [7:0]         cols_eff;
  logic [CELLS_W-1:0] cells_raw, cells;
  bswr_cmd_t          cmd;
  bswr_sts_t          sts;
  logic [6:0]         cell_code;
  logic [CUR_W-1:0]   cursor_position;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= 6'd24;
      column_count_r <= 8'd80;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROWS: row_count_r    <= cfg_data[5:0];
        REG_COLS: column_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_eff  = (row_count_r == 6'd0) ? 6'd1 : ((row_count_r > 6'd32) ? 6'd32 : row_count_r);
    cols_eff  = (column_count_r == 8'd0) ? 8'd1
              : ((column_count_r > 8'd128) ? 8'd128 : column_count_r);
    cells_raw = CELLS_W'(rows_eff * cols_eff);
    cells     = (cells_raw > CELLS_W'(CELL_CAP)) ? CELLS_W'(CELL_CAP) : cells_raw;
  end

  bswr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bswr_dp #(
    .MAX_CELLS (MAX_CELLS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .eff_cols   (cols_eff),
    .cells      (cells),
    .in_action  (in_tuser),
    .in_last    (in_tlast),
    .in_byte    (in_tdata[7:0]),
    .in_addr    (in_tdata[19:8]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_cell   (cell_code),
    .out_cursor (cursor_position)
  );

  assign out_tdata = {5'd0, cursor_position, cell_code};

endmodule
`default_nettype wire

>>> src/bswr_dp.sv
// Datapath: screen memory, cursor, operands, remainder unit and result register.
`timescale 1ns / 1ps
`default_nettype none
module bswr_dp
  import bswr_pkg::*;
#(
  parameter int MAX_CELLS = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bswr_cmd_t          cmd,
  output bswr_sts_t               sts,
  input  wire logic [7:0]         eff_cols,
  input  wire logic [CELLS_W-1:0] cells,
  input  wire logic               in_action,
  input  wire logic               in_last,
  input  wire logic [7:0]         in_byte,
  input  wire logic [11:0]        in_addr,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [6:0]              out_cell,
  output logic [CUR_W-1:0]        out_cursor
);

  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CELLS - 1);

  logic [6:0]         mem [MAX_CELLS];
  logic [6:0]         rdata_r;
  logic [7:0]         byte_r, row_r, col_r, fill_r, skip_r;
  logic               last_r, action_r, rd_in_r;
  logic [11:0]        addr_r;
  logic [CUR_W-1:0]   cursor_r, target_r;
  logic               tgt_ok_r, neg_r;
  logic [CELLS_W-1:0] guard_r;
  logic signed [N_W-1:0] n_r;
  logic [AW-1:0]      clr_addr_r;
  logic [DIV_W-1:0]   div_r;
  logic [CELLS_W-1:0] rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               out_valid_r;
  logic [6:0]         out_cell_r;
  logic [CUR_W-1:0]   out_cursor_r;

  logic [CELLS_W-1:0] cur_inc;
  logic [7:0]         r_eff, c_eff;
  logic signed [9:0]  rm1, cm1;
  logic signed [N_W-1:0] n_calc, n_mag;
  logic [CELLS_W:0]   trial;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [6:0]         mem_wd;

  assign cur_inc = {1'b0, cursor_r} + 13'd1;

  always_comb begin
    r_eff  = (cmd.clamp && row_r == 8'd0) ? 8'd1 : row_r;
    c_eff  = cmd.clamp ? ((byte_r == 8'd0) ? 8'd1 : byte_r) : col_r;
    rm1    = $signed({2'b00, r_eff}) - 10'sd1;
    cm1    = $signed({2'b00, c_eff}) - 10'sd1;
    n_calc = N_W'(rm1 * $signed({2'b00, eff_cols})) + N_W'(cm1);
    n_mag  = neg_r ? -n_r : n_r;
    trial  = {rem_r, div_r[DIV_W-1]};
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = AW'(cursor_r);
    mem_wd = cmd.wr_fill ? ebc_to_ascii(fill_r) : ebc_to_ascii(byte_r);
    if (cmd.clr_wr) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = SPACE_CODE;
    end else if (cmd.wr_cell && ({1'b0, cursor_r} < cells)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd_mem) begin
      rdata_r <= mem[AW'(addr_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      cursor_r    <= '0;
      row_r       <= '0;
      col_r       <= '0;
      skip_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_addr_r <= clr_addr_r + AW'(1);
      if (cmd.latch_in) begin
        byte_r   <= in_byte;
        last_r   <= in_last;
        action_r <= in_action;
        addr_r   <= in_addr;
        rd_in_r  <= (32'(in_addr) < MAX_CELLS);
      end
      if (cmd.ld_row) row_r <= byte_r;
      if (cmd.ld_col) col_r <= byte_r;
      if (cmd.ld_fill) fill_r <= byte_r;
      if (cmd.ld_n) begin
        n_r   <= n_calc;
        neg_r <= n_calc[N_W-1];
      end
      if (cmd.ld_skip) skip_r <= byte_r;
      if (cmd.dec_skip) skip_r <= skip_r - 8'd1;
      if (cmd.clr_ops) begin
        row_r  <= '0;
        col_r  <= '0;
        skip_r <= '0;
      end
      if (cmd.wr_cell) begin
        if (cmd.wr_fill) guard_r <= guard_r - CELLS_W'(1);
        if (cur_inc == cells) cursor_r <= '0;
        else if (cur_inc < cells) cursor_r <= cur_inc[CUR_W-1:0];
      end
      if (cmd.mod_start) begin
        rem_r  <= '0;
        div_r  <= cmd.mod_src_cur ? DIV_W'(cur_inc) : n_mag[DIV_W-1:0];
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= (trial >= {1'b0, cells}) ? CELLS_W'(trial - {1'b0, cells})
                                           : CELLS_W'(trial);
        div_r  <= {div_r[DIV_W-2:0], 1'b0};
        cnt_r  <= cnt_r + CNT_W'(1);
        if (cnt_r == '1) busy_r <= 1'b0;
      end
      if (cmd.cur_from_rem) cursor_r <= rem_r[CUR_W-1:0];
      if (cmd.tgt_from_rem) begin
        target_r <= rem_r[CUR_W-1:0];
        tgt_ok_r <= !neg_r || (rem_r == '0);
        guard_r  <= cells;
      end
      if (cmd.out_load) begin
        out_valid_r  <= 1'b1;
        out_cell_r   <= rd_in_r ? rdata_r : SPACE_CODE;
        out_cursor_r <= cursor_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.data_byte = byte_r;
    sts.last      = last_r;
    sts.action    = action_r;
    sts.skip_gt1  = skip_r > 8'd1;
    sts.adv_slow  = cur_inc > cells;
    sts.mod_busy  = busy_r;
    sts.fill_go   = (cursor_r != target_r || !tgt_ok_r) && guard_r != '0;
    sts.clr_last  = clr_addr_r == LAST_ADDR;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_cell   = out_cell_r;
  assign out_cursor = out_cursor_r;

  a_load_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while full");
  a_port_excl : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !cmd.wr_cell && !cmd.rd_mem)
    else $error("memory port used twice");
  a_mod_len : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> cnt_r == '0)
    else $error("remainder unit started mid-count");

endmodule
`default_nettype wire

>>> src/bswr_ctrl.sv
// Controller: beat acceptance, order parser and sequencing of datapath steps.
`timescale 1ns / 1ps
`default_nettype none
module bswr_ctrl
  import bswr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire bswr_sts_t sts,
  output bswr_cmd_t      cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0, S_IDLE = 3'd1, S_EXEC = 3'd2, S_NMOD = 3'd3,
                         S_MOD = 3'd4, S_FILL = 3'd5, S_RD = 3'd6, S_OUT = 3'd7;

  localparam logic [3:0] PH_IDLE = 4'd0, PH_ESC_CMD = 4'd1, PH_WTD_A = 4'd2,
                         PH_WTD_B = 4'd3, PH_SBA_ROW = 4'd4, PH_SBA_COL = 4'd5,
                         PH_RA_ROW = 4'd6, PH_RA_COL = 4'd7, PH_RA_FILL = 4'd8,
                         PH_SF_SKIP = 4'd9, PH_SOH_LEN = 4'd10, PH_SOH_SKIP = 4'd11;

  localparam logic [1:0] D_CUR = 2'd0, D_TGT = 2'd1, D_FILL = 2'd2;

  localparam logic [7:0] C_ESC = 8'h04, C_SBA = 8'h11, C_RA = 8'h02, C_SF = 8'h1D,
                         C_IC = 8'h13, C_SOH = 8'h01;

  logic [2:0] state_r, state_nxt;
  logic [3:0] phase_r, phase_nxt;
  logic [1:0] dst_r, dst_nxt;
  logic [3:0] ib_phase;
  logic       ib_write;
  logic       write_now;

  always_comb begin
    ib_phase = PH_IDLE;
    ib_write = 1'b0;
    case (sts.data_byte)
      C_ESC: if (sts.last) ib_write = 1'b1; else ib_phase = PH_ESC_CMD;
      C_SBA: ib_phase = PH_SBA_ROW;
      C_RA:  ib_phase = PH_RA_ROW;
      C_SF:  ib_phase = PH_SF_SKIP;
      C_IC:  ib_phase = PH_IDLE;
      C_SOH: ib_phase = PH_SOH_LEN;
      default: ib_write = 1'b1;
    endcase
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    phase_nxt = phase_r;
    dst_nxt   = dst_r;
    write_now = 1'b0;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (sts.action) begin
          state_nxt = S_RD;
        end else begin
          phase_nxt = PH_IDLE;
          unique case (phase_r)
            PH_ESC_CMD: if (sts.data_byte == C_SBA) phase_nxt = PH_WTD_A;
            PH_WTD_A: begin
              if (sts.last) begin
                phase_nxt = ib_phase;
                write_now = ib_write;
              end else begin
                phase_nxt = PH_WTD_B;
              end
            end
            PH_WTD_B, PH_SF_SKIP: phase_nxt = PH_IDLE;
            PH_SBA_ROW: begin
              cmd.ld_row = 1'b1;
              phase_nxt  = PH_SBA_COL;
            end
            PH_SBA_COL: begin
              cmd.ld_n  = 1'b1;
              cmd.clamp = 1'b1;
              dst_nxt   = D_CUR;
              state_nxt = S_NMOD;
            end
            PH_RA_ROW: begin
              cmd.ld_row = 1'b1;
              phase_nxt  = PH_RA_COL;
            end
            PH_RA_COL: begin
              cmd.ld_col = 1'b1;
              phase_nxt  = PH_RA_FILL;
            end
            PH_RA_FILL: begin
              cmd.ld_n    = 1'b1;
              cmd.ld_fill = 1'b1;
              dst_nxt     = D_TGT;
              state_nxt   = S_NMOD;
            end
            PH_SOH_LEN: begin
              cmd.ld_skip = 1'b1;
              if (sts.data_byte != 8'd0) phase_nxt = PH_SOH_SKIP;
            end
            PH_SOH_SKIP: begin
              cmd.dec_skip = 1'b1;
              if (sts.skip_gt1) phase_nxt = PH_SOH_SKIP;
            end
            default: begin
              phase_nxt = ib_phase;
              write_now = ib_write;
            end
          endcase
          if (write_now) begin
            cmd.wr_cell = 1'b1;
            if (sts.adv_slow) begin
              cmd.mod_start   = 1'b1;
              cmd.mod_src_cur = 1'b1;
              dst_nxt         = D_CUR;
              state_nxt       = S_MOD;
            end
          end
          if (sts.last) begin
            phase_nxt   = PH_IDLE;
            cmd.clr_ops = 1'b1;
          end
        end
      end
      S_NMOD: begin
        cmd.mod_start = 1'b1;
        state_nxt     = S_MOD;
      end
      S_MOD: begin
        if (!sts.mod_busy) begin
          unique case (dst_r)
            D_TGT: begin
              cmd.tgt_from_rem = 1'b1;
              state_nxt        = S_FILL;
            end
            D_FILL: begin
              cmd.cur_from_rem = 1'b1;
              state_nxt        = S_FILL;
            end
            default: begin
              cmd.cur_from_rem = 1'b1;
              state_nxt        = S_IDLE;
            end
          endcase
        end
      end
      S_FILL: begin
        if (sts.fill_go) begin
          cmd.wr_cell = 1'b1;
          cmd.wr_fill = 1'b1;
          if (sts.adv_slow) begin
            cmd.mod_start   = 1'b1;
            cmd.mod_src_cur = 1'b1;
            dst_nxt         = D_FILL;
            state_nxt       = S_MOD;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd_mem = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      phase_r <= PH_IDLE;
      dst_r   <= D_CUR;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      dst_r   <= dst_nxt;
    end
  end

  a_rec_end : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && !sts.action && sts.last) |=> phase_r == PH_IDLE)
    else $error("parser state kept across record end");
  a_idle_mod : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_EXEC) |-> !sts.mod_busy)
    else $error("remainder unit busy while taking beats");
  a_fill_src : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_fill |-> state_r == S_FILL && cmd.wr_cell)
    else $error("fill write outside fill loop");

endmodule
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the terminal stream screen writer: random byte streams and cell reads.
`timescale 1ns / 1ps
module tb;
  import bswr_pkg::*;

  localparam int MAXC = 4096;
  localparam logic [7:0] B_ESC = 8'h04, B_SBA = 8'h11, B_RA = 8'h02, B_SF = 8'h1D,
                         B_IC = 8'h13, B_SOH = 8'h01;
  localparam logic REG_ROWS = 1'b0, REG_COLS = 1'b1;

  typedef enum logic [3:0] {
    P_IDLE, P_ESC, P_WTD_A, P_WTD_B, P_SBA_R, P_SBA_C, P_RA_R, P_RA_C, P_RA_F,
    P_SF, P_SOH_LEN, P_SOH_SKIP
  } phase_e;

  typedef struct packed {
    logic [6:0]  code;
    logic [11:0] cur;
  } cell_read_t;

  class screen_scoreboard;
    logic [6:0]  screen [MAXC];
    int unsigned cursor, op_row, op_col, skip_left, rows, cols;
    phase_e      phase;
    cell_read_t  pending [$];
    int          errors;

    function void clear();
      foreach (screen[i]) screen[i] = 7'h20;
      cursor = 0; op_row = 0; op_col = 0; skip_left = 0; rows = 24; cols = 80;
      phase = P_IDLE; errors = 0;
    endfunction

    function int unsigned ncols();
      int unsigned c;
      c = cols; if (c < 1) c = 1; if (c > 128) c = 128;
      return c;
    endfunction

    function int unsigned ncells();
      int unsigned r, n;
      r = rows; if (r < 1) r = 1; if (r > 32) r = 32;
      n = r * ncols(); if (n > MAXC) n = MAXC;
      return n;
    endfunction

    function void put_char(logic [7:0] b);
      int unsigned n;
      n = ncells();
      if (cursor < n) screen[cursor] = xlate(b);
      cursor = (cursor + 1) % n;
    endfunction

    function logic [6:0] xlate(logic [7:0] c);
      if (c >= 8'hF0 && c <= 8'hF9) return 7'h30 + 7'(c - 8'hF0);
      if (c >= 8'hC1 && c <= 8'hC9) return 7'h41 + 7'(c - 8'hC1);
      if (c >= 8'hD1 && c <= 8'hD9) return 7'h4A + 7'(c - 8'hD1);
      if (c >= 8'hE2 && c <= 8'hE9) return 7'h53 + 7'(c - 8'hE2);
      if (c >= 8'h81 && c <= 8'h89) return 7'h61 + 7'(c - 8'h81);
      if (c >= 8'h91 && c <= 8'h99) return 7'h6A + 7'(c - 8'h91);
      if (c >= 8'hA2 && c <= 8'hA9) return 7'h73 + 7'(c - 8'hA2);
      case (c)
        8'h4B: return 7'h2E; 8'h6B: return 7'h2C; 8'h60: return 7'h2D;
        8'h61: return 7'h2F; 8'h7A: return 7'h3A; 8'h5C: return 7'h2A;
        8'h4D: return 7'h28; 8'h5D: return 7'h29; 8'h50: return 7'h26;
        8'h7C: return 7'h40; 8'h5B: return 7'h24; 8'h6C: return 7'h25;
        default: return 7'h20;
      endcase
    endfunction

    function void idle_byte(logic [7:0] b, bit last);
      case (b)
        B_ESC: if (last) put_char(b); else phase = P_ESC;
        B_SBA: phase = P_SBA_R;
        B_RA:  phase = P_RA_R;
        B_SF:  phase = P_SF;
        B_IC:  ;
        B_SOH: phase = P_SOH_LEN;
        default: put_char(b);
      endcase
    endfunction

    function void repeat_to(logic [7:0] fill);
      int n, target;
      int unsigned cells, guard;
      cells = ncells(); guard = cells;
      n = (int'(op_row) - 1) * int'(ncols()) + (int'(op_col) - 1);
      target = n % int'(cells);
      while (int'(cursor) != target && guard > 0) begin
        guard--;
        put_char(fill);
      end
    endfunction

    function void note_input(bit action, logic [7:0] b, bit last, logic [11:0] addr);
      phase_e ph;
      cell_read_t r;
      if (action) begin
        r.code = (addr < MAXC) ? screen[addr] : 7'h20;
        r.cur = cursor[11:0];
        pending.push_back(r);
        return;
      end
      ph = phase; phase = P_IDLE;
      case (ph)
        P_ESC:   if (b == B_SBA) phase = P_WTD_A;
        P_WTD_A: if (last) idle_byte(b, last); else phase = P_WTD_B;
        P_WTD_B: ;
        P_SBA_R: begin op_row = b; phase = P_SBA_C; end
        P_SBA_C: begin
          op_col = b;
          cursor = (((op_row < 1 ? 1 : op_row) - 1) * ncols() +
                    ((op_col < 1 ? 1 : op_col) - 1)) % ncells();
        end
        P_RA_R:  begin op_row = b; phase = P_RA_C; end
        P_RA_C:  begin op_col = b; phase = P_RA_F; end
        P_RA_F:  repeat_to(b);
        P_SF:    ;
        P_SOH_LEN: begin skip_left = b; if (b > 0) phase = P_SOH_SKIP; end
        P_SOH_SKIP: begin
          if (skip_left > 0) skip_left--;
          if (skip_left > 0) phase = P_SOH_SKIP;
        end
        default: idle_byte(b, last);
      endcase
      if (last) begin
        phase = P_IDLE; op_row = 0; op_col = 0; skip_left = 0;
      end
    endfunction

    function void check_read(logic [23:0] d);
      cell_read_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected read beat %h", d);
        return;
      end
      e = pending.pop_front();
      if (d[6:0] !== e.code || d[18:7] !== e.cur || d[23:19] !== 5'd0) begin
        errors++;
        if (errors <= 10)
          $display("read mismatch: exp code %h cursor %0d, got code %h cursor %0d",
                   e.code, e.cur, d[6:0], d[18:7]);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tlast = 0, in_tuser = 0;
  logic [23:0] in_tdata = '0;
  logic in_tready, out_tvalid, cfg_ready;
  logic out_tready = 0;
  logic [23:0] out_tdata;
  logic cfg_valid = 0, cfg_index = 0;
  logic [7:0] cfg_data = '0;
  bit quiet = 0;
  screen_scoreboard sb;

  block_terminal_stream_screen_writer dut (.*);

  always #1 clk = ~clk;

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stall bursts, none near the end.
  initial begin
    int k;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 0;
        k = $urandom_range(1, 4);
        repeat (k) @(negedge clk);
      end
      out_tready <= 1;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_read(out_tdata);

  // The block drops in_tready after each taken beat, so the closing wait costs nothing.
  task automatic send(bit action, logic [7:0] b, bit last, logic [11:0] addr);
    int k;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      k = $urandom_range(1, 4);
      repeat (k) @(negedge clk);
    end
    in_tvalid <= 1; in_tuser <= action; in_tlast <= last;
    in_tdata <= {4'd0, addr, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(action, b, last, addr);
    @(negedge clk);
    in_tvalid <= 0;
    @(negedge clk);
  endtask

  task automatic feed(logic [7:0] b, bit last = 0);
    send(0, b, last, 12'($urandom));
  endtask

  task automatic peek(logic [11:0] addr);
    send(1, 8'($urandom), $urandom_range(0, 1), addr);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10000) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_ROWS) sb.rows = v & 8'h3F; else sb.cols = v;
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return B_ESC; 1: return B_SBA; 2: return B_RA; 3: return B_SF;
      4: return B_IC;  5: return B_SOH;
      6: return 8'($urandom_range(8'hC1, 8'hC9));
      7: return 8'($urandom_range(8'hF0, 8'hF9));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick_addr();
    if ($urandom_range(0, 7) == 0) return 12'($urandom);
    return 12'($urandom_range(0, sb.ncells() - 1));
  endfunction

  task automatic random_record();
    int len, j;
    len = $urandom_range(1, 10);
    for (j = 0; j < len; j++) begin
      if ($urandom_range(0, 4) == 0) peek(pick_addr());
      case ($urandom_range(0, 7))
        0: begin feed(B_SBA); feed(8'($urandom_range(0, 33)));
             feed(8'($urandom_range(0, 130))); end
        1: begin feed(B_RA); feed(8'($urandom_range(0, 33)));
             feed(8'($urandom_range(0, 130))); feed(pick_byte()); end
        2: begin feed(B_ESC); feed($urandom_range(0, 1) ? B_SBA : 8'($urandom)); end
        3: begin feed(B_SOH); feed(8'($urandom_range(0, 4))); end
        default: feed(pick_byte());
      endcase
    end
    feed(pick_byte(), 1);
  endtask

  initial begin
    int i, ph;
    sb = new();
    sb.clear();
    repeat (3) @(negedge clk);
    rst_n <= 1;

    // Directed: extremes, every order, cut-short orders and the escape cases.
    peek(12'd0); peek(12'hFFF);
    feed(8'hC1); feed(8'hF9); feed(8'h00); feed(8'hFF); feed(8'h4B);
    feed(B_IC); feed(B_SF); feed(8'hC2);
    feed(B_ESC); feed(B_SBA); feed(8'hAA); feed(8'hBB); feed(8'hE2);
    feed(B_ESC); feed(B_SBA); feed(8'hC3, 1);
    feed(B_ESC, 1);
    feed(B_SBA); feed(8'd0); feed(8'd0);
    feed(B_SBA); feed(8'd255); feed(8'd255);
    feed(B_RA); feed(8'd2); feed(8'd5); feed(8'h81);
    feed(B_RA); feed(8'd0); feed(8'd0); feed(8'h5C);
    feed(B_SOH); feed(8'd2); feed(8'hC4); feed(8'hC5); feed(8'hC6);
    feed(B_SBA); feed(8'd3, 1);
    feed(B_SOH); feed(8'd255); feed(8'hC7, 1);
    peek(12'd0); peek(12'd80); peek(12'd85); peek(12'd1919); peek(12'd1);
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_ROWS, 8'd32); write_reg(REG_COLS, 8'd128); end
        1: begin write_reg(REG_ROWS, 8'd1); write_reg(REG_COLS, 8'd1); end
        2: begin write_reg(REG_ROWS, 8'd0); write_reg(REG_COLS, 8'd0); end
        3: begin write_reg(REG_ROWS, 8'hFF); write_reg(REG_COLS, 8'd200); end
        4: begin write_reg(REG_ROWS, 8'd4); write_reg(REG_COLS, 8'd10); end
        default: begin write_reg(REG_ROWS, 8'd24); write_reg(REG_COLS, 8'd80); end
      endcase
      if (ph == 5) quiet = 1;
      i = 0;
      while (i < 280) begin
        random_record();
        i += 12;
        if (ph == 2 && i > 100 && i < 113) begin
          while (sb.pending.size() != 0) @(negedge clk);
        end
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

>>> sim.f
src/bswr_pkg.sv
src/bswr_dp.sv
src/bswr_ctrl.sv
src/block_terminal_stream_screen_writer.sv
dv/tb.sv
